// ===== rtl/rgb2lab_pkg.sv =====
`default_nettype none

package rgb2lab_pkg;

  // Default number of fractional bits carried inside the datapath.
  localparam int FRAC_BITS_DEF = 16;

  // Port widths.
  localparam int IN_W = 17;
  localparam int L_W  = 17;
  localparam int AB_W = 19;

  // Width of a colour matrix coefficient (Q.18, all below 1.0).
  localparam int COEF_W = 18;
  // Width of the linear slope constant (Q.18, below 8.0).
  localparam int K_W = 21;

  typedef logic [COEF_W-1:0] coef_t;

  // RGB to XYZ matrix in Q.18, one row per output channel.
  localparam coef_t MAT [0:2][0:2] = '{
    '{18'd113754, 18'd98618,  18'd49764},
    '{18'd55751,  18'd187473, 18'd18920},
    '{18'd4654,   18'd28692,  18'd228757}
  };

  // Companding and output constants, all Q.18.
  localparam longint C_EPS  = 2322;
  localparam longint C_S    = 36158;
  localparam longint C_K    = 2041325;
  localparam longint C_L    = 304087;
  localparam longint C_AOFF = 102713;
  localparam longint C_AMUL = 595782;
  localparam longint C_BOFF = 128570;
  localparam longint C_BMUL = 238313;

  // Output saturation bounds in Q.16.
  localparam longint L_MAX  = 131071;
  localparam longint AB_MIN = -196608;
  localparam longint AB_MAX = 196607;

  // Brings a positive Q.18 constant to Q.f, rounding to nearest.
  function automatic longint q18_to_qf(input longint c, input int f);
    return ((c <<< f) + 64'sd131072) >>> 18;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_to_lab_convert_unit.sv =====
// Linear RGB to Lab-like pixel converter.
//
// Input beat: red, green and blue (unsigned Q1.16) are taken at a rising
// edge where start is high and busy is low. Busy is always low, so a new
// pixel may be offered in every cycle and the sustained rate is one pixel
// per clock.
// Result beat: lightness (unsigned Q1.16), chroma_a and chroma_b (signed
// Q2.16) sit on their ports for exactly one cycle while done is high, and
// are taken at the edge that ends that cycle. The receiver cannot stall.
// Pipeline: FRAC_BITS + 1 stages are the cube root, which settles one
// result bit per stage in all three channels at once; the rest are the
// matrix products, their sum, the companding select, the output
// multiplies and the final rounding and saturation.
// Results leave in the order the pixels came in.
// Reset is synchronous: it clears every valid bit, so pixels in flight are
// dropped and done is low in the cycle after reset. The data registers are not reset.
`default_nettype none

module rgb_to_lab_convert_unit
  import rgb2lab_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [IN_W-1:0]        red,
  input  logic [IN_W-1:0]        green,
  input  logic [IN_W-1:0]        blue,
  output logic                   done,
  output logic [L_W-1:0]         lightness,
  output logic signed [AB_W-1:0] chroma_a,
  output logic signed [AB_W-1:0] chroma_b
);

  // Widths that follow from the fractional precision.
  localparam int PRW  = IN_W + COEF_W;        // matrix product
  localparam int MSH  = 34 - FRAC_BITS;       // matrix product rounding shift
  localparam int VW   = FRAC_BITS + 2;        // X, Y, Z (below 4.0)
  localparam int LPW  = VW + K_W;             // linear slope product
  localparam int NS   = FRAC_BITS + 1;        // cube root stages
  localparam int YW   = FRAC_BITS + 1;        // partial root
  localparam int QW   = 2 * FRAC_BITS + 2;    // square of the partial root
  localparam int REMW = 2 * FRAC_BITS + 4;    // root remainder
  localparam int RW   = REMW + 3;             // remainder with next digit
  localparam int EW   = 3 * FRAC_BITS + 3;    // radicand padded to whole digits
  localparam int CW   = FRAC_BITS + 3;        // companded value, signed
  localparam int PW   = CW + 22;              // output products, signed

  // Constants brought to Q.F; the output multipliers and their rounding term stay in Q.18.
  localparam logic [VW-1:0]        EPSQ  = VW'(q18_to_qf(C_EPS, FRAC_BITS));
  localparam logic signed [CW-1:0] SQ    = CW'(q18_to_qf(C_S, FRAC_BITS));
  localparam logic signed [PW-1:0] AOFFQ = PW'(q18_to_qf(C_AOFF, FRAC_BITS));
  localparam logic signed [PW-1:0] BOFFQ = PW'(q18_to_qf(C_BOFF, FRAC_BITS));
  localparam logic signed [PW-1:0] LMUL  = PW'(C_L);
  localparam logic signed [PW-1:0] AMUL  = PW'(C_AMUL);
  localparam logic signed [PW-1:0] BMUL  = PW'(C_BMUL);
  localparam logic signed [PW-1:0] RND18 = PW'(64'sd131072);

  // Scaling from Q.F to Q.16: rounded right shift or plain left shift.
  localparam int DSH = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int USH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [PW-1:0] ORND = PW'((64'sd1 <<< DSH) >>> 1);

  localparam logic signed [PW-1:0] LMAXQ  = PW'(L_MAX);
  localparam logic signed [PW-1:0] ABMINQ = PW'(AB_MIN);
  localparam logic signed [PW-1:0] ABMAXQ = PW'(AB_MAX);

  logic [IN_W-1:0] pix [0:2];

  logic            mvld;
  logic [PRW-1:0]  mprod [0:2][0:2];

  logic            vvld;
  logic [VW-1:0]   xyz [0:2];
  logic [VW-1:0]   xyz_next [0:2];

  logic [FRAC_BITS-1:0] lin_now [0:2];
  logic [2:0]           above_now;

  logic [NS-1:0]        cvld;
  logic [VW-1:0]        cf [0:NS-1][0:2];
  logic [YW-1:0]        cy [0:NS-1][0:2];
  logic [QW-1:0]        cq [0:NS-1][0:2];
  logic [REMW-1:0]      crem [0:NS-1][0:2];
  logic [FRAC_BITS-1:0] clin [0:NS-1][0:2];
  logic [2:0]           cabove [0:NS-1];
  logic [VW-1:0]        cf_next [0:NS-1][0:2];
  logic [YW-1:0]        cy_next [0:NS-1][0:2];
  logic [QW-1:0]        cq_next [0:NS-1][0:2];
  logic [REMW-1:0]      crem_next [0:NS-1][0:2];
  logic [FRAC_BITS-1:0] clin_next [0:NS-1][0:2];
  logic [2:0]           cabove_next [0:NS-1];

  logic                 kvld;
  logic signed [CW-1:0] comp [0:2];

  logic                 pvld;
  logic signed [PW-1:0] pl;
  logic signed [PW-1:0] pa;
  logic signed [PW-1:0] pb;
  logic signed [CW:0]   dxy;
  logic signed [CW:0]   dyz;

  logic signed [PW-1:0] lsat;
  logic signed [PW-1:0] asat;
  logic signed [PW-1:0] bsat;

  // Every cycle can take a pixel.
  assign busy = 1'b0;

  assign pix[0] = red;
  assign pix[1] = green;
  assign pix[2] = blue;

  // Valid bits travel alongside the data; reset empties the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= 1'b0;
      vvld <= 1'b0;
      cvld <= '0;
      kvld <= 1'b0;
      pvld <= 1'b0;
      done <= 1'b0;
    end else begin
      mvld <= start;
      vvld <= mvld;
      cvld <= {cvld[NS-2:0], vvld};
      kvld <= cvld[NS-1];
      pvld <= kvld;
      done <= pvld;
    end
  end

  // Stage one: the nine matrix products.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mprod[r][c] <= PRW'(pix[c]) * PRW'(MAT[r][c]);
      end
    end
  end

  // Stage two: each product is rounded to Q.F and the rows are summed.
  always_comb begin
    logic [PRW-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int c = 0; c < 3; c++) begin
        acc = acc + ((mprod[r][c] + (PRW'(1) << (MSH - 1))) >> MSH);
      end
      xyz_next[r] = acc[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      xyz[r] <= xyz_next[r];
    end
  end

  // Linear branch and threshold test, formed as the value enters the root.
  always_comb begin
    logic [LPW-1:0] lprod;
    logic [LPW-1:0] lrnd;
    for (int c = 0; c < 3; c++) begin
      lprod        = LPW'(xyz[c]) * LPW'(C_K);
      lrnd         = (lprod + (LPW'(1) << 17)) >> 18;
      lin_now[c]   = lrnd[FRAC_BITS-1:0];
      above_now[c] = xyz[c] > EPSQ;
    end
  end

  // Cube root, one result bit per stage: the remainder takes the next three
  // radicand bits and the trial subtrahend is 12*y^2 + 6*y + 1, built from
  // the running square so that no multiplier is needed.
  always_comb begin
    logic [VW-1:0]   f_in;
    logic [YW-1:0]   y_in;
    logic [QW-1:0]   q_in;
    logic [REMW-1:0] rem_in;
    logic [EW-1:0]   ext;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic            take;
    for (int s = 0; s < NS; s++) begin
      cabove_next[s] = (s == 0) ? above_now : cabove[(s == 0) ? 0 : s - 1];
      for (int c = 0; c < 3; c++) begin
        if (s == 0) begin
          f_in            = xyz[c];
          y_in            = '0;
          q_in            = '0;
          rem_in          = '0;
          clin_next[s][c] = lin_now[c];
        end else begin
          f_in            = cf[s-1][c];
          y_in            = cy[s-1][c];
          q_in            = cq[s-1][c];
          rem_in          = crem[s-1][c];
          clin_next[s][c] = clin[s-1][c];
        end
        ext    = {1'b0, f_in, {(2 * FRAC_BITS){1'b0}}};
        rem_sh = {rem_in, ext[3 * (NS - 1 - s) +: 3]};
        trial  = (RW'(q_in) << 3) + (RW'(q_in) << 2) + (RW'(y_in) << 2)
               + (RW'(y_in) << 1) + RW'(1);
        take   = rem_sh >= trial;
        cf_next[s][c] = f_in;
        cy_next[s][c] = {y_in[YW-2:0], take};
        if (take) begin
          crem_next[s][c] = REMW'(rem_sh - trial);
          cq_next[s][c]   = QW'({q_in, 2'b00}) + QW'({y_in, 2'b00}) + QW'(1);
        end else begin
          crem_next[s][c] = REMW'(rem_sh);
          cq_next[s][c]   = QW'({q_in, 2'b00});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      cabove[s] <= cabove_next[s];
      for (int c = 0; c < 3; c++) begin
        cf[s][c]   <= cf_next[s][c];
        cy[s][c]   <= cy_next[s][c];
        cq[s][c]   <= cq_next[s][c];
        crem[s][c] <= crem_next[s][c];
        clin[s][c] <= clin_next[s][c];
      end
    end
  end

  // Companding select: root minus 4/29 above the threshold, else the slope.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cabove[NS-1][c]) begin
        comp[c] <= $signed({2'b00, cy[NS-1][c]}) - SQ;
      end else begin
        comp[c] <= $signed({3'b000, clin[NS-1][c]});
      end
    end
  end

  // Output multiplies on the companded values.
  assign dxy = (CW+1)'(comp[0]) - (CW+1)'(comp[1]);
  assign dyz = (CW+1)'(comp[1]) - (CW+1)'(comp[2]);

  always_ff @(posedge clk) begin
    pl <= PW'(comp[1]) * LMUL;
    pa <= PW'(dxy) * AMUL;
    pb <= PW'(dyz) * BMUL;
  end

  // Final rounding, offsets, scaling to Q.16 and saturation.
  always_comb begin
    logic signed [PW-1:0] lq;
    logic signed [PW-1:0] aq;
    logic signed [PW-1:0] bq;
    lq = ((((pl + RND18) >>> 18) + ORND) >>> DSH) <<< USH;
    aq = ((((pa + RND18) >>> 18) + AOFFQ + ORND) >>> DSH) <<< USH;
    bq = ((((pb + RND18) >>> 18) + BOFFQ + ORND) >>> DSH) <<< USH;
    lsat = (lq < 0) ? '0 : ((lq > LMAXQ) ? LMAXQ : lq);
    asat = (aq < ABMINQ) ? ABMINQ : ((aq > ABMAXQ) ? ABMAXQ : aq);
    bsat = (bq < ABMINQ) ? ABMINQ : ((bq > ABMAXQ) ? ABMAXQ : bq);
  end

  always_ff @(posedge clk) begin
    lightness <= lsat[L_W-1:0];
    chroma_a  <= asat[AB_W-1:0];
    chroma_b  <= bsat[AB_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/rgb2lab_check.sv =====
`default_nettype none

module rgb2lab_check
  import rgb2lab_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   done,
  input wire logic signed [AB_W-1:0] chroma_a,
  input wire logic signed [AB_W-1:0] chroma_b
);

  // Edges from an accepted input beat to its result beat.
  localparam int LAT = FRAC_BITS + 6;

  // Every accepted pixel gives a result beat after the fixed latency.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted pixel produced no result beat");

  // No result beat appears without a pixel taken that long before.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !done)
    else $error("result beat straight after reset");

  // Both chroma outputs stay inside their saturation range.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (chroma_a >= AB_MIN) && (chroma_a <= AB_MAX)
          && (chroma_b >= AB_MIN) && (chroma_b <= AB_MAX))
    else $error("chroma outside the saturation range");

endmodule

bind rgb_to_lab_convert_unit rgb2lab_check #(.FRAC_BITS(FRAC_BITS)) u_check (.*);

`default_nettype wire

// ===== test/rgb_to_lab_convert_unit_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_lab_convert_unit_tb;
  import rgb2lab_pkg::*;

  // Datapath precision of the instance under test and its pipeline depth.
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = FB + 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PIXELS = 1950;
  localparam int MID_DRAIN_AT = 1000;

  typedef struct {
    logic [IN_W-1:0] red;
    logic [IN_W-1:0] green;
    logic [IN_W-1:0] blue;
  } rgb_pixel_t;

  typedef struct {
    logic [L_W-1:0]         lightness;
    logic signed [AB_W-1:0] chroma_a;
    logic signed [AB_W-1:0] chroma_b;
  } lab_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [IN_W-1:0] red = '0;
  logic [IN_W-1:0] green = '0;
  logic [IN_W-1:0] blue = '0;
  logic busy;
  logic done;
  logic [L_W-1:0] lightness;
  logic signed [AB_W-1:0] chroma_a;
  logic signed [AB_W-1:0] chroma_b;

  rgb_pixel_t pending_px[$];
  lab_pixel_t lab_expect[$];
  logic beat_taken = 1'b0;
  logic drain_wait = 1'b0;
  int sent_cnt = 0;
  int directed_n = 0;
  int burst_left = 1;
  int gap_left = 0;
  int idle_cycles = 0;
  int err_cnt = 0;

  rgb_to_lab_convert_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .done      (done),
    .lightness (lightness),
    .chroma_a  (chroma_a),
    .chroma_b  (chroma_b)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Rounds p / 2^n to nearest, ties toward plus infinity.
  function automatic longint round_shift(input longint p, input int n);
    return (p + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // A Q.F value times a Q.18 constant, rounded back to Q.F.
  function automatic longint mul_q18(input longint a, input longint c);
    return round_shift(a * c, 18);
  endfunction

  // A Q.18 constant brought to Q.F.
  function automatic longint const_qf(input longint c);
    return mul_q18(64'sd1 <<< FB, c);
  endfunction

  // One row of the RGB to XYZ matrix, each product rounded before the sum.
  function automatic longint xyz_row(input rgb_pixel_t px, input int idx);
    longint acc;
    acc = round_shift(longint'(px.red) * longint'(MAT[idx][0]), 34 - FB);
    acc += round_shift(longint'(px.green) * longint'(MAT[idx][1]), 34 - FB);
    acc += round_shift(longint'(px.blue) * longint'(MAT[idx][2]), 34 - FB);
    return acc;
  endfunction

  // Companding: floor cube root less 4/29 above the threshold, linear slope at or below.
  function automatic longint compand(input longint v);
    longint lo;
    longint hi;
    longint mid;
    longint radicand;
    if (v <= const_qf(C_EPS)) begin
      return mul_q18(v, C_K);
    end
    radicand = v <<< (2 * FB);
    lo = 0;
    hi = 64'sd1 <<< 18;
    while (hi - lo > 1) begin
      mid = (lo + hi) >>> 1;
      if (mid * mid * mid <= radicand) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo - const_qf(C_S);
  endfunction

  // Output rounding to Q.16 and saturation.
  function automatic longint clamp_out(input longint v, input longint lo, input longint hi);
    longint r;
    if (FB > 16) begin
      r = round_shift(v, FB - 16);
    end else begin
      r = v <<< (16 - FB);
    end
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  // Expected Lab pixel for one RGB pixel.
  function automatic lab_pixel_t predict_lab(input rgb_pixel_t px);
    lab_pixel_t lab;
    longint cx;
    longint cy;
    longint cz;
    longint l_val;
    longint a_val;
    longint b_val;
    cx = compand(xyz_row(px, 0));
    cy = compand(xyz_row(px, 1));
    cz = compand(xyz_row(px, 2));
    l_val = clamp_out(mul_q18(cy, C_L), 0, L_MAX);
    a_val = clamp_out(const_qf(C_AOFF) + mul_q18(cx - cy, C_AMUL), AB_MIN, AB_MAX);
    b_val = clamp_out(const_qf(C_BOFF) + mul_q18(cy - cz, C_BMUL), AB_MIN, AB_MAX);
    lab.lightness = l_val[L_W-1:0];
    lab.chroma_a = a_val[AB_W-1:0];
    lab.chroma_b = b_val[AB_W-1:0];
    return lab;
  endfunction

  // One colour component drawn from a chosen region of the input range.
  function automatic logic [IN_W-1:0] random_level(input int kind);
    case (kind)
      0, 1, 2, 3, 4: begin
        return IN_W'($urandom_range(0, 65536));
      end
      5: begin
        return IN_W'($urandom_range(0, 2500));
      end
      6: begin
        return ($urandom_range(0, 1) == 1) ? IN_W'(65536) : IN_W'(0);
      end
      default: begin
        return IN_W'($urandom_range(0, 131071));
      end
    endcase
  endfunction

  task automatic push_pixel(input int r, input int g, input int b);
    rgb_pixel_t px;
    px.red = IN_W'(r);
    px.green = IN_W'(g);
    px.blue = IN_W'(b);
    pending_px.insert(pending_px.size(), px);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Driver: feeds pixels in bursts, holding each beat until it is taken.
  always @(negedge clk) begin
    rgb_pixel_t px;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // The offered beat was not taken yet, so it stays on the ports.
    end else if (drain_wait) begin
      start <= 1'b0;
      if (lab_expect.size() == 0) drain_wait <= 1'b0;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_px.size() != 0) begin
      px = pending_px.pop_front();
      red <= px.red;
      green <= px.green;
      blue <= px.blue;
      start <= 1'b1;
      sent_cnt <= sent_cnt + 1;
      if (sent_cnt + 1 == directed_n || sent_cnt + 1 == MID_DRAIN_AT) drain_wait <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks each result beat against the oldest prediction, then
  // records the prediction for an input beat taken at this edge.
  always @(posedge clk) begin
    rgb_pixel_t px;
    lab_pixel_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (done) begin
        if (lab_expect.size() == 0) begin
          report_mismatch("result beat with no pixel pending, lightness", lightness, 0);
        end else begin
          want = lab_expect.pop_front();
          if (lightness !== want.lightness)
            report_mismatch("lightness", lightness, want.lightness);
          if (chroma_a !== want.chroma_a)
            report_mismatch("chroma_a", chroma_a, want.chroma_a);
          if (chroma_b !== want.chroma_b)
            report_mismatch("chroma_b", chroma_b, want.chroma_b);
        end
      end
      if (start && !busy) begin
        px.red = red;
        px.green = green;
        px.blue = blue;
        lab_expect.insert(lab_expect.size(), predict_lab(px));
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", lab_expect.size());
        $display("rgb_to_lab_convert_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    rgb_pixel_t probe;
    int kind;
    int found;

    // Directed pixels: black, white, over-range white, primaries and pairs, and greys just above black and below white.
    push_pixel(0, 0, 0);
    push_pixel(65536, 65536, 65536);
    push_pixel(131071, 131071, 131071);
    push_pixel(65536, 0, 0);
    push_pixel(0, 65536, 0);
    push_pixel(0, 0, 65536);
    push_pixel(131071, 0, 0);
    push_pixel(0, 131071, 0);
    push_pixel(0, 0, 131071);
    push_pixel(131071, 131071, 0);
    push_pixel(0, 131071, 131071);
    push_pixel(131071, 0, 131071);
    push_pixel(1, 1, 1);
    push_pixel(65535, 65535, 65535);
    push_pixel(65536, 0, 65536);

    // Grey levels whose X, Y or Z lands on the threshold or just above it.
    found = 0;
    for (int v = 0; v <= 1500 && found < 8; v++) begin
      probe.red = IN_W'(v);
      probe.green = IN_W'(v);
      probe.blue = IN_W'(v);
      for (int idx = 0; idx < 3; idx++) begin
        if (xyz_row(probe, idx) == const_qf(C_EPS) ||
            xyz_row(probe, idx) == const_qf(C_EPS) + 1) begin
          push_pixel(v, v, v);
          found++;
          break;
        end
      end
    end
    directed_n = pending_px.size();

    // Random pixels, mostly in range, some near the threshold and some over range.
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      kind = $urandom_range(0, 9);
      probe.red = random_level(kind);
      probe.green = random_level(kind);
      probe.blue = random_level(kind);
      pending_px.insert(pending_px.size(), probe);
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_px.size() != 0 || start) @(posedge clk);
    while (lab_expect.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (lab_expect.size() != 0)
      report_mismatch("results still outstanding at the end", lab_expect.size(), 0);
    if (err_cnt == 0) begin
      $display("rgb_to_lab_convert_unit verification clean");
    end else begin
      $display("rgb_to_lab_convert_unit verification failed");
    end
    $finish;
  end

endmodule
